// ===== src/overwrite_ring_history_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the history ring
// Shared property wrappers; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_RING_HISTORY_BUFFER_DEFINES_SVH
`define OVERWRITE_RING_HISTORY_BUFFER_DEFINES_SVH

// Same-cycle implication, muted during reset
`define ORHB_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("history ring check failed");

// Next-cycle implication, muted during reset
`define ORHB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("history ring check failed");

`endif

// ===== src/ohb_pkg.sv =====
// ----------------------------------------------------------------------------
// ohb_pkg
// Sizes, codes and shared types of the overwriting history ring.
// ----------------------------------------------------------------------------
package ohb_pkg;

  // Ring geometry
  localparam int DEPTH       = 64;
  localparam int RECORD_BITS = 64;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Field widths fixed by the interface
  localparam int OP_W  = 2;
  localparam int REQ_W = 7;
  localparam int CFG_W = 7;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

  // Operation codes on the input word
  localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
  localparam logic [OP_W-1:0] OP_SNAPSHOT = 2'd1;
  localparam logic [OP_W-1:0] OP_LATEST   = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_SNAPSHOT,
    CMD_LATEST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [RECORD_BITS-1:0] record;
    logic [REQ_W-1:0]       count;
  } cmd_t;

  typedef struct packed {
    logic [RECORD_BITS-1:0] record;
    logic                   valid;
    logic                   last;
    logic [CNT_W-1:0]       fill;
  } result_t;

  typedef struct packed {
    logic             clear;
    logic [CNT_W-1:0] capacity;
  } cfg_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// ===== src/ohb_front.sv =====
// ----------------------------------------------------------------------------
// ohb_front
// Input handshake and command classification; unused codes are dropped.
// ----------------------------------------------------------------------------
module ohb_front (
  input  logic [1:0]    operation,
  input  logic [63:0]   record_in,
  input  logic [6:0]    request_count,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          q_push,
  output ohb_pkg::cmd_t q_data,
  input  logic          q_full
);
  import ohb_pkg::*;

  logic known_op;

  // Classify the word into a back-end command
  always_comb begin
    known_op      = 1'b1;
    q_data.record = record_in[RECORD_BITS-1:0];
    q_data.count  = request_count;
    q_data.kind   = CMD_PUSH;
    unique case (operation)
      OP_PUSH: begin
        q_data.kind = CMD_PUSH;
      end
      OP_SNAPSHOT: begin
        q_data.kind = CMD_SNAPSHOT;
      end
      OP_LATEST: begin
        // latest is a snapshot of one
        q_data.kind  = CMD_LATEST;
        q_data.count = REQ_W'(1);
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
  end

  // Accept whenever the queue has room; unknown words are swallowed
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && known_op;

endmodule

// ===== src/ohb_queue.sv =====
// ----------------------------------------------------------------------------
// ohb_queue
// Short command FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
module ohb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ohb_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output ohb_pkg::cmd_t pop_data,
  output logic          empty
);
  import ohb_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   used;

  // no room while in reset, so nothing is taken and lost
  assign full     = rst || (used == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (used == '0);
  assign pop_data = slots[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      used <= used + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== src/ohb_back.sv =====
// ----------------------------------------------------------------------------
// ohb_back
// Ring memory, head and fill state, query sequencer and result buffer.
// ----------------------------------------------------------------------------
module ohb_back (
  input  logic             clk,
  input  logic             rst,
  input  ohb_pkg::cfg_t    cfg,
  input  logic             cmd_empty,
  input  ohb_pkg::cmd_t    cmd_data,
  output logic             cmd_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output ohb_pkg::result_t out_word
);
  import ohb_pkg::*;

  // Ring memory
  logic [RECORD_BITS-1:0] mem [DEPTH];

  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  count;

  back_state_t state;
  back_state_t state_next;
  logic [ADDR_W-1:0] slot;
  logic [CNT_W-1:0]  remain;

  // Decoded command
  logic              is_push;
  logic [CNT_W-1:0]  n_sel;
  logic [ADDR_W-1:0] first_slot;
  logic [CNT_W:0]    head_w;
  logic [CNT_W:0]    n_w;
  logic [CNT_W:0]    cap_w;
  logic [CNT_W:0]    first_w;

  // Sequencer controls
  logic              do_push;
  logic              issue;
  logic              issue_ok;
  logic              load_run;
  logic              iss_rec;
  logic              iss_last;
  logic [ADDR_W-1:0] iss_addr;

  // Read stage
  logic                   rd_valid;
  logic                   rd_rec;
  logic                   rd_last;
  logic [CNT_W-1:0]       rd_fill;
  logic [RECORD_BITS-1:0] rd_data;

  // Two-entry result buffer
  result_t    obuf [2];
  logic       o_wr;
  logic       o_rd;
  logic [1:0] o_cnt;
  logic       o_pop;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] s,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] t;
    t = (CNT_W + 1)'(s) + (CNT_W + 1)'(1);
    if (t >= (CNT_W + 1)'(cap)) begin
      t = '0;
    end
    return ADDR_W'(t);
  endfunction

  // Command decode: run length and slot of its oldest record
  always_comb begin
    is_push = (cmd_data.kind == CMD_PUSH);
    if (cmd_data.count == '0 || 32'(cmd_data.count) > 32'(count)) begin
      n_sel = count;
    end else begin
      n_sel = CNT_W'(cmd_data.count);
    end
    head_w = (CNT_W + 1)'(head);
    n_w    = (CNT_W + 1)'(n_sel);
    cap_w  = (CNT_W + 1)'(cfg.capacity);
    if (head_w >= n_w) begin
      first_w = head_w - n_w;
    end else begin
      first_w = head_w + cap_w - n_w;
    end
    first_slot = ADDR_W'(first_w);
  end

  // Issue a read only when the result buffer will have room for it
  assign o_pop    = out_valid && out_ready;
  assign issue_ok = (3'(o_cnt) + 3'(rd_valid) - 3'(o_pop)) < 3'd2;

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (load_run) state_next = BK_RUN;
      end
      BK_RUN: begin
        if (issue && iss_last) state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_pop  = 1'b0;
    do_push  = 1'b0;
    issue    = 1'b0;
    load_run = 1'b0;
    iss_rec  = 1'b0;
    iss_last = 1'b0;
    iss_addr = slot;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          if (is_push) begin
            cmd_pop = 1'b1;
            do_push = 1'b1;
          end else if (issue_ok) begin
            cmd_pop  = 1'b1;
            issue    = 1'b1;
            iss_addr = first_slot;
            if (count == '0) begin
              // empty ring: one word marked invalid
              iss_last = 1'b1;
            end else begin
              iss_rec  = 1'b1;
              iss_last = (n_sel == CNT_W'(1));
              load_run = (n_sel != CNT_W'(1));
            end
          end
        end
      end
      BK_RUN: begin
        if (issue_ok) begin
          issue    = 1'b1;
          iss_rec  = 1'b1;
          iss_last = (remain == CNT_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      head     <= '0;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (cfg.clear) begin
        head  <= '0;
        count <= '0;
      end else if (do_push) begin
        head <= wrap_inc(head, cfg.capacity);
        if (count < cfg.capacity) count <= count + 1'b1;
      end
    end
  end

  // Run position and read-stage tags
  always_ff @(posedge clk) begin
    if (load_run) begin
      slot   <= wrap_inc(first_slot, cfg.capacity);
      remain <= n_sel - 1'b1;
    end else if (state == BK_RUN && issue) begin
      slot   <= wrap_inc(slot, cfg.capacity);
      remain <= remain - 1'b1;
    end
    if (issue) begin
      rd_rec  <= iss_rec;
      rd_last <= iss_last;
      rd_fill <= count;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (do_push) mem[head] <= cmd_data.record;
    if (issue)   rd_data   <= mem[iss_addr];
  end

  // Result buffer pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr  <= 1'b0;
      o_rd  <= 1'b0;
      o_cnt <= '0;
    end else begin
      if (rd_valid) o_wr <= !o_wr;
      if (o_pop)    o_rd <= !o_rd;
      o_cnt <= o_cnt + 2'(rd_valid) - 2'(o_pop);
    end
  end

  // Result buffer storage
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      obuf[o_wr].record <= rd_rec ? rd_data : '0;
      obuf[o_wr].valid  <= rd_rec;
      obuf[o_wr].last   <= rd_last;
      obuf[o_wr].fill   <= rd_fill;
    end
  end

  assign out_valid = (o_cnt != '0);
  assign out_word  = obuf[o_rd];

endmodule

// ===== src/overwrite_ring_history_buffer.sv =====
// ----------------------------------------------------------------------------
// overwrite_ring_history_buffer
// History ring keeping the newest records, overwriting the oldest when full.
// ----------------------------------------------------------------------------
// Words enter through a four-deep command queue, so the input side keeps
// taking words while results wait. A push yields no result word; pushes
// stream at one per cycle while the back end is idle, not running a snapshot.
// A snapshot of n records issues one read of the single ring memory port
// per record, holding while the result buffer lacks room, and a latest or
// empty query issues one read; results leave one per cycle from a two-word
// buffer while out_ready is high, each read passing the read register first.
// Writing the capacity register empties the ring at once; there is no clearing
// pass after reset, since slots that were never written are never read.
module overwrite_ring_history_buffer (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [63:0]                 record_in,
  input  logic [6:0]                  request_count,
  // result words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 record_out,
  output logic                        record_valid,
  output logic                        last_of_run,
  output logic [6:0]                  fill_level,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ohb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ohb_pkg::*;

  logic             q_push;
  cmd_t             q_in;
  logic             q_full;
  logic             q_pop;
  cmd_t             q_out;
  logic             q_empty;
  result_t          res;
  cfg_t             cfg;
  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] cap_clamped;
  logic [CFG_W-1:0] wr_val;
  logic             cap_wr;

  // Configuration register: capacity, clamped to 1..DEPTH on write
  assign pready = 1'b1;
  assign cap_wr = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1:2] == REG_CAPACITY);
  assign wr_val = pwdata[CFG_W-1:0];

  always_comb begin
    if (wr_val == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (32'(wr_val) > 32'(DEPTH)) begin
      cap_clamped = CNT_W'(DEPTH);
    end else begin
      cap_clamped = CNT_W'(wr_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(DEPTH);
    end else if (cap_wr) begin
      capacity <= cap_clamped;
    end
  end

  assign prdata       = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? 32'(capacity) : '0;
  assign cfg.clear    = cap_wr;
  assign cfg.capacity = capacity;

  ohb_front u_front (
    .operation     (operation),
    .record_in     (record_in),
    .request_count (request_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .q_push        (q_push),
    .q_data        (q_in),
    .q_full        (q_full)
  );

  ohb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ohb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (q_empty),
    .cmd_data  (q_out),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (res)
  );

  // Result word fields
  assign record_out   = 64'(res.record);
  assign record_valid = res.valid;
  assign last_of_run  = res.last;
  assign fill_level   = 7'(res.fill);

endmodule

// ===== src/ohb_checker.sv =====
// ----------------------------------------------------------------------------
// ohb_checker
// Port-level checks of the history ring result channel.
// ----------------------------------------------------------------------------
`include "overwrite_ring_history_buffer_defines.svh"

module ohb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] record_out,
  input logic        record_valid,
  input logic        last_of_run,
  input logic [6:0]  fill_level
);
  import ohb_pkg::*;

  // A stalled result word holds
  `ORHB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(record_out) && $stable(last_of_run))

  // An empty-ring answer is a lone, zeroed word
  `ORHB_ASSERT_IMPLY(a_empty_form, out_valid && !record_valid, last_of_run && fill_level == '0 && record_out == '0)

  // A returned record implies a nonempty ring
  `ORHB_ASSERT_IMPLY(a_fill_nonzero, out_valid && record_valid, fill_level != '0)

  // Fill never exceeds the ring depth
  `ORHB_ASSERT_IMPLY(a_fill_range, out_valid, 32'(fill_level) <= 32'(DEPTH))

endmodule

bind overwrite_ring_history_buffer ohb_checker u_ohb_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .record_out   (record_out),
  .record_valid (record_valid),
  .last_of_run  (last_of_run),
  .fill_level   (fill_level)
);
